/* design/crc16_byte_framer_defines.svh */
// Assertion macros shared by the framer checker.
`ifndef CRC16_BYTE_FRAMER_DEFINES_SVH
`define CRC16_BYTE_FRAMER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define CRCBF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define CRCBF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/crcbf_pkg.sv */
// Shared types, register indexes and the CRC-16 byte update for the framer.
package crcbf_pkg;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [7:0]  LEN_RESET = 8'd67;

	// Configuration register indexes
	localparam logic [7:0] REG_SYNC = 8'd0;
	localparam logic [7:0] REG_TYPE = 8'd1;
	localparam logic [7:0] REG_END  = 8'd2;
	localparam logic [7:0] REG_LEN  = 8'd3;

	// Positions in the output run of one payload byte
	typedef enum logic [2:0] {
		SLOT_SYNC  = 3'd0,
		SLOT_TYPE  = 3'd1,
		SLOT_LEN   = 3'd2,
		SLOT_DATA  = 3'd3,
		SLOT_CRCHI = 3'd4,
		SLOT_CRCLO = 3'd5,
		SLOT_END   = 3'd6
	} slot_t;

	typedef struct packed {
		logic [7:0] sync_byte;
		logic [7:0] frame_type;
		logic [7:0] end_byte;
		logic [7:0] payload_length;
	} cfg_t;

	typedef struct packed {
		logic       hdr;
		logic       tail;
		logic [7:0] data;
	} item_t;

	// CRC-16 CCITT update with one byte, MSB first
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

/* design/crcbf_cfg.sv */
// Configuration register file of the framer.
module crcbf_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [7:0]          cfg_index,
	input  logic [7:0]          cfg_data,
	output crcbf_pkg::cfg_t     cfg
);

	crcbf_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	// Write the addressed register, drop writes to unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_byte      <= 8'd0;
			cfg_q.frame_type     <= 8'd0;
			cfg_q.end_byte       <= 8'd0;
			cfg_q.payload_length <= crcbf_pkg::LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				crcbf_pkg::REG_SYNC: cfg_q.sync_byte      <= cfg_data;
				crcbf_pkg::REG_TYPE: cfg_q.frame_type     <= cfg_data;
				crcbf_pkg::REG_END:  cfg_q.end_byte       <= cfg_data;
				crcbf_pkg::REG_LEN:  cfg_q.payload_length <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

/* design/crcbf_seq.sv */
// Frame position counter: marks each incoming byte as first and/or last of its frame.
module crcbf_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          payload_byte,
	input  logic [7:0]          payload_length,
	output crcbf_pkg::item_t    item
);

	logic [7:0] count_q;
	logic [7:0] count_inc;

	assign count_inc = count_q + 8'd1;

	// Classify the byte on offer against the current count
	always_comb begin
		item.hdr  = (count_q == 8'd0);
		item.tail = (count_inc == payload_length);
		item.data = payload_byte;
	end

	// Advance the count on each accepted beat, wrap to zero at frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 8'd0;
		end else if (accept) begin
			count_q <= item.tail ? 8'd0 : count_inc;
		end
	end

endmodule

/* design/crcbf_emit.sv */
// Item register and run emitter: walks header, data and trailer slots, runs the CRC.
module crcbf_emit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  crcbf_pkg::item_t    item,
	input  crcbf_pkg::cfg_t     cfg,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          out_byte,
	output logic                run_last,
	output logic                frame_end
);

	crcbf_pkg::item_t item_s1;
	logic             valid_s1;
	crcbf_pkg::slot_t slot_q;
	logic [15:0]      crc_q;
	crcbf_pkg::slot_t last_slot;
	logic             out_beat;
	logic             accept;

	assign last_slot = item_s1.tail ? crcbf_pkg::SLOT_END : crcbf_pkg::SLOT_DATA;
	assign out_valid = valid_s1;
	assign run_last  = (slot_q == last_slot);
	assign frame_end = (slot_q == crcbf_pkg::SLOT_END);
	assign out_beat  = valid_s1 && out_ready;
	assign in_ready  = !valid_s1 || (out_ready && run_last);
	assign accept    = in_valid && in_ready;

	// Select the byte for the current slot
	always_comb begin
		case (slot_q)
			crcbf_pkg::SLOT_SYNC:  out_byte = cfg.sync_byte;
			crcbf_pkg::SLOT_TYPE:  out_byte = cfg.frame_type;
			crcbf_pkg::SLOT_LEN:   out_byte = cfg.payload_length;
			crcbf_pkg::SLOT_DATA:  out_byte = item_s1.data;
			crcbf_pkg::SLOT_CRCHI: out_byte = crc_q[15:8];
			crcbf_pkg::SLOT_CRCLO: out_byte = crc_q[7:0];
			crcbf_pkg::SLOT_END:   out_byte = cfg.end_byte;
			default:               out_byte = item_s1.data;
		endcase
	end

	// Hold the item payload until its run is done
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	// Load a new run, advance the slot, or drop the finished run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			slot_q   <= crcbf_pkg::SLOT_DATA;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			slot_q   <= item.hdr ? crcbf_pkg::SLOT_SYNC : crcbf_pkg::SLOT_DATA;
		end else if (out_beat) begin
			if (run_last) begin
				valid_s1 <= 1'b0;
			end else begin
				slot_q <= crcbf_pkg::slot_t'(slot_q + 3'd1);
			end
		end
	end

	// Feed the CRC with type, length and data as each beat leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= crcbf_pkg::CRC_INIT;
		end else if (out_beat) begin
			case (slot_q)
				crcbf_pkg::SLOT_TYPE: crc_q <= crcbf_pkg::crc_feed(crcbf_pkg::CRC_INIT,
						cfg.frame_type);
				crcbf_pkg::SLOT_LEN:  crc_q <= crcbf_pkg::crc_feed(crc_q, cfg.payload_length);
				crcbf_pkg::SLOT_DATA: crc_q <= crcbf_pkg::crc_feed(crc_q, item_s1.data);
				default: ;
			endcase
		end
	end

endmodule

/* design/crc16_byte_framer.sv */
// The first output beat of a byte is valid in the cycle after the byte is taken.
// One beat per cycle while out_ready is high; a middle byte gives its data beat only, a first
// byte adds sync, type and length before it, a last byte adds CRC and end beats after it.
// The next byte is taken in the cycle the last beat of the current run leaves.
// Reset: arst_n clears the frame count, CRC, output run and registers (length 67).
module crc16_byte_framer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] payload_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       frame_end,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_index,
	input  logic [7:0] cfg_data
);

	crcbf_pkg::cfg_t  cfg;
	crcbf_pkg::item_t item;

	crcbf_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	crcbf_seq u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (in_valid && in_ready),
		.payload_byte   (payload_byte),
		.payload_length (cfg.payload_length),
		.item           (item)
	);

	crcbf_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.item      (item),
		.cfg       (cfg),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.run_last  (run_last),
		.frame_end (frame_end)
	);

endmodule

/* design/crcbf_chk.sv */
// Port-level checker for the framer, bound to the top level.
`include "crc16_byte_framer_defines.svh"

module crcbf_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       run_last,
	input logic       frame_end
);

	// A trailer beat always closes its run
	`CRCBF_ASSERT_NOW(a_end_is_last, out_valid && frame_end, run_last,
		"trailer beat not marked last")
	// With nothing pending the block takes input
	`CRCBF_ASSERT_NOW(a_idle_ready, !out_valid, in_ready, "idle but not ready")
	// An accepted byte shows a beat next cycle
	`CRCBF_ASSERT_NEXT(a_accept_out, in_valid && in_ready, out_valid,
		"accepted byte produced no beat")
	// The last beat leaving with no new byte empties the output
	`CRCBF_ASSERT_NEXT(a_drain, out_valid && out_ready && run_last && !(in_valid && in_ready),
		!out_valid, "output still valid after run drained")
	// A stalled beat holds its byte
	`CRCBF_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready,
		out_valid && $stable(out_byte), "stalled beat changed")

endmodule

bind crc16_byte_framer crcbf_chk u_chk (.*);

/* tb/framer_stream_check.sv */
`timescale 1ns / 1ps
// Framer stream checker: predicts the framed bytes of every payload beat and checks the output.
module framer_stream_check (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] payload_byte,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] out_byte,
	input  logic       run_last,
	input  logic       frame_end,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic [7:0] cfg_index,
	input  logic [7:0] cfg_data,
	output int         fail_count,
	output int         pending,
	output int         bytes_taken,
	output int         beats_checked,
	output int         frames_checked
);

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       trailer;
	} framed_beat_t;

	framed_beat_t      expected_beats[$];
	framed_beat_t      head;
	crcbf_pkg::cfg_t   shadow_cfg;
	logic [15:0]       crc_acc;
	logic [7:0]        frame_pos;

	// Shift one byte into a CCITT CRC, MSB first, one feedback bit at a time
	function automatic logic [15:0] ccitt_shift_in(input logic [15:0] acc, input logic [7:0] b);
		logic [15:0] r;
		logic        fb;
		r = acc;
		for (int i = 7; i >= 0; i--) begin
			fb = r[15] ^ b[i];
			r = {r[14:0], 1'b0};
			if (fb) begin
				r = r ^ crcbf_pkg::CRC_POLY;
			end
		end
		return r;
	endfunction

	// Work out the run of framed beats that one payload byte causes and queue it
	function automatic void frame_payload_byte(input logic [7:0] b);
		framed_beat_t run [7];
		int           n;
		n = 0;
		// open a frame: sync, type, length; type and length go into the CRC
		if (frame_pos == 8'd0) begin
			crc_acc = crcbf_pkg::CRC_INIT;
			run[0] = '{shadow_cfg.sync_byte, 1'b0, 1'b0};
			run[1] = '{shadow_cfg.frame_type, 1'b0, 1'b0};
			run[2] = '{shadow_cfg.payload_length, 1'b0, 1'b0};
			crc_acc = ccitt_shift_in(crc_acc, shadow_cfg.frame_type);
			crc_acc = ccitt_shift_in(crc_acc, shadow_cfg.payload_length);
			n = 3;
		end
		run[n] = '{b, 1'b0, 1'b0};
		n++;
		crc_acc = ccitt_shift_in(crc_acc, b);
		frame_pos = frame_pos + 8'd1;
		// close the frame once the 8-bit count meets the length
		if (frame_pos == shadow_cfg.payload_length) begin
			run[n] = '{crc_acc[15:8], 1'b0, 1'b0};
			run[n + 1] = '{crc_acc[7:0], 1'b0, 1'b0};
			run[n + 2] = '{shadow_cfg.end_byte, 1'b0, 1'b1};
			n += 3;
			frame_pos = 8'd0;
			crc_acc = crcbf_pkg::CRC_INIT;
		end
		run[n - 1].last = 1'b1;
		for (int i = 0; i < n; i++) begin
			expected_beats.push_back(run[i]);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_cfg = '{8'h00, 8'h00, 8'h00, crcbf_pkg::LEN_RESET};
			crc_acc = crcbf_pkg::CRC_INIT;
			frame_pos = 8'd0;
			expected_beats.delete();
		end else begin
			// track register writes; unknown indexes are dropped
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					crcbf_pkg::REG_SYNC: shadow_cfg.sync_byte = cfg_data;
					crcbf_pkg::REG_TYPE: shadow_cfg.frame_type = cfg_data;
					crcbf_pkg::REG_END:  shadow_cfg.end_byte = cfg_data;
					crcbf_pkg::REG_LEN:  shadow_cfg.payload_length = cfg_data;
					default: ;
				endcase
			end
			// compare the beat leaving against the oldest expectation
			if (out_valid && out_ready) begin
				beats_checked++;
				if (expected_beats.size() == 0) begin
					$error("unexpected output beat: out_byte %02h run_last %0b frame_end %0b",
						out_byte, run_last, frame_end);
					fail_count++;
				end else begin
					head = expected_beats.pop_front();
					if (head.trailer) begin
						frames_checked++;
					end
					if (out_byte !== head.data) begin
						$error("out_byte: expected %02h, got %02h", head.data, out_byte);
						fail_count++;
					end
					if (run_last !== head.last) begin
						$error("run_last: expected %0b, got %0b", head.last, run_last);
						fail_count++;
					end
					if (frame_end !== head.trailer) begin
						$error("frame_end: expected %0b, got %0b", head.trailer, frame_end);
						fail_count++;
					end
				end
			end
			// predict the run of each accepted payload beat
			if (in_valid && in_ready) begin
				bytes_taken++;
				frame_payload_byte(payload_byte);
			end
		end
		pending = expected_beats.size();
	end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Top of the framer testbench: clock, reset, payload and register stimulus, verdict.
module tb_top;

	localparam int LIMIT_CYCLES = 400000;
	localparam int HOLD_CYCLES  = 60;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic [7:0] payload_byte = 8'h00;
	logic       out_ready = 1'b0;
	logic       cfg_valid = 1'b0;
	logic [7:0] cfg_index = 8'h00;
	logic [7:0] cfg_data = 8'h00;
	logic       in_ready;
	logic       out_valid;
	logic [7:0] out_byte;
	logic       run_last;
	logic       frame_end;
	logic       cfg_ready;

	int         fail_count;
	int         pending;
	int         bytes_taken;
	int         beats_checked;
	int         frames_checked;
	int         send_idle = 26;
	int         recv_idle = 80;
	int         hold_left = 0;
	logic       hold_req = 1'b0;
	logic [7:0] frame_len = crcbf_pkg::LEN_RESET;
	int         cycle_count = 0;

	crc16_byte_framer u_top (.*);

	framer_stream_check u_stream_check (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Drive out_ready: a requested hold-off first, else random idling
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	function automatic logic [7:0] pick_octet();
		case ($urandom_range(3))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// Write one register; call only with no beat outstanding
	task automatic set_reg(input logic [7:0] idx, input logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
		if (idx == crcbf_pkg::REG_LEN) begin
			frame_len = value;
		end
	endtask

	// Offer one payload beat, with a random gap before it
	task automatic send_byte(input logic [7:0] b);
		if ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_idle);
		end
		in_valid <= 1'b1;
		payload_byte <= b;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic send_frame_bytes(input int n);
		for (int i = 0; i < n; i++) begin
			send_byte(8'($urandom));
		end
	endtask

	// Drop valid and hold until every expected beat has left
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	// Whole frames with random content; registers change only between frames
	task automatic random_frames(input int n_bytes);
		int sent;
		sent = 0;
		while (sent < n_bytes) begin
			if (sent == 0 || $urandom_range(2) == 0) begin
				drain_results();
				if ($urandom_range(1) == 1) set_reg(crcbf_pkg::REG_SYNC, pick_octet());
				if ($urandom_range(1) == 1) set_reg(crcbf_pkg::REG_TYPE, pick_octet());
				if ($urandom_range(1) == 1) set_reg(crcbf_pkg::REG_END, pick_octet());
				if ($urandom_range(5) == 0) set_reg(8'($urandom_range(4, 255)), pick_octet());
				set_reg(crcbf_pkg::REG_LEN, ($urandom_range(7) == 0)
					? 8'($urandom_range(9, 24)) : 8'($urandom_range(1, 8)));
			end
			send_frame_bytes(frame_len);
			sent += frame_len;
		end
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// one frame at the reset register values
		send_frame_bytes(crcbf_pkg::LEN_RESET);
		drain_results();

		// one-byte frames: the whole header and trailer from a single beat
		set_reg(crcbf_pkg::REG_SYNC, 8'hFF);
		set_reg(crcbf_pkg::REG_TYPE, 8'h00);
		set_reg(crcbf_pkg::REG_END, 8'hFF);
		set_reg(crcbf_pkg::REG_LEN, 8'd1);
		send_byte(8'h00);
		send_byte(8'hFF);
		drain_results();

		// short frame with the opposite register extremes
		set_reg(crcbf_pkg::REG_SYNC, 8'h00);
		set_reg(crcbf_pkg::REG_TYPE, 8'hFF);
		set_reg(crcbf_pkg::REG_END, 8'h00);
		set_reg(crcbf_pkg::REG_LEN, 8'd3);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'h5A);
		drain_results();

		// writes to indexes past the register file must be dropped
		set_reg(8'd4, 8'h33);
		set_reg(8'hFF, 8'hCC);

		// shorten the length mid-frame, still ahead of the count; swap the trailer too
		set_reg(crcbf_pkg::REG_LEN, 8'd4);
		send_byte(8'h80);
		send_byte(8'h01);
		drain_results();
		set_reg(crcbf_pkg::REG_LEN, 8'd3);
		set_reg(crcbf_pkg::REG_END, 8'h7E);
		send_byte(8'h7F);
		drain_results();

		// hold the output off while the sender keeps offering, then pause the sender
		set_reg(crcbf_pkg::REG_LEN, 8'd12);
		hold_req = 1'b1;
		send_frame_bytes(12);
		drain_results();

		random_frames(10);

		// swap idling: slow sender, busy receiver
		send_idle = 80;
		recv_idle = 26;
		drain_results();

		random_frames(10);

		// no idling on either side
		send_idle = 0;
		recv_idle = 0;
		random_frames(10);

		drain_results();
		repeat (8) @(negedge clk);

		$display("Covered %0d payload beats in %0d frames, %0d output beats checked",
			bytes_taken, frames_checked, beats_checked);
		$display("Lengths 1, 3, 12, 67 and random short frames, mid-frame length edits, ignored indexes");
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

/* crc16_byte_framer.f */
+incdir+design
design/crcbf_pkg.sv
design/crcbf_cfg.sv
design/crcbf_seq.sv
design/crcbf_emit.sv
design/crc16_byte_framer.sv
design/crcbf_chk.sv
tb/framer_stream_check.sv
tb/tb_top.sv
